// File: hw/rtl/ghrq_pkg.sv
package ghrq_pkg;

    localparam int VALUE_W       = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int NUM_CONTROLS  = 4;
    localparam int NUM_AXES      = 2;

    localparam int DEFAULT_REPEAT_PERIOD = 1;
    localparam int DEFAULT_COUNTER_WIDTH = 16;

    localparam logic [CFG_W-1:0] RESET_DEADZONE     = 16'd200;
    localparam logic [CFG_W-1:0] RESET_MIDPOINT     = 16'd32768;
    localparam logic [CFG_W-1:0] RESET_REPEAT_DELAY = 16'd15;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_BUTTON = 2'd1,
        FUNC_AXIS   = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEADZONE     = 2'd0,
        CFG_MIDPOINT     = 2'd1,
        CFG_REPEAT_DELAY = 2'd2
    } cfg_index_t;

endpackage

// File: hw/rtl/gamepad_hold_repeat_qualifier_unit.sv
// Gamepad hold/repeat qualifier. Takes button events, axis events and frame ticks
// (func) and returns one result transaction per input transaction: fire flags for
// A, B, x and y, the stored stick positions and their direction against the midpoint.
// Throughput is one transaction per clock while out_stall is low; each transaction passes
// through the input register (where event_value is multiplied by the reciprocal of
// REPEAT_PERIOD) and then the result register, where the counter update and fire check
// happen. The result register lets a new input be taken while a finished result is stalled.
// Each counter carries its residue modulo REPEAT_PERIOD so the repeat check needs no
// divider. Configuration writes (cfg_we) are expected only while the block is idle.
module gamepad_hold_repeat_qualifier_unit
    import ghrq_pkg::*;
#(
    parameter int REPEAT_PERIOD = DEFAULT_REPEAT_PERIOD,
    parameter int COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
)(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             func,
    input  logic                   control_index,
    input  logic [VALUE_W-1:0]     event_value,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   fire_a,
    output logic                   fire_b,
    output logic                   fire_x,
    output logic                   fire_y,
    output logic [VALUE_W-1:0]     x_position,
    output logic [VALUE_W-1:0]     y_position,
    output logic                   x_negative,
    output logic                   y_negative
);

    localparam int LOAD_W    = (COUNTER_WIDTH < VALUE_W) ? COUNTER_WIDTH : VALUE_W;
    localparam int SHIFT_L   = $clog2(REPEAT_PERIOD);
    localparam int DIV_SHIFT = LOAD_W + SHIFT_L;
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_SHIFT) + REPEAT_PERIOD - 1) / REPEAT_PERIOD;
    localparam int RECIP_W   = LOAD_W + 1;
    localparam int PROD_W    = LOAD_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;
    localparam int RES_W     = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;
    localparam int CMP_W     = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

    localparam logic [RES_W-1:0] RES_ONE  = RES_W'(1 % REPEAT_PERIOD);
    localparam logic [RES_W-1:0] RES_TWO  = RES_W'(2 % REPEAT_PERIOD);
    localparam logic [RES_W-1:0] RES_LAST = RES_W'(REPEAT_PERIOD - 1);

    // configuration
    logic [CFG_W-1:0] deadzone_reg;
    logic [CFG_W-1:0] midpoint_reg;
    logic [CFG_W-1:0] repeat_delay_reg;

    // input register
    logic                in_vld_reg;
    func_t               stage_func_reg;
    logic                stage_idx_reg;
    logic [VALUE_W-1:0]  stage_val_reg;
    logic [PROD_W-1:0]   stage_prod_reg;
    logic [PROD_W-1:0]   prod_next;

    // state
    logic [COUNTER_WIDTH-1:0] hold_reg  [NUM_CONTROLS];
    logic [COUNTER_WIDTH-1:0] hold_next [NUM_CONTROLS];
    logic [RES_W-1:0]         res_reg   [NUM_CONTROLS];
    logic [RES_W-1:0]         res_next  [NUM_CONTROLS];
    logic [VALUE_W-1:0]       pos_reg   [NUM_AXES];
    logic [VALUE_W-1:0]       pos_next  [NUM_AXES];

    // result register
    logic                     out_vld_reg;
    logic [NUM_CONTROLS-1:0]  fire_reg;
    logic [NUM_CONTROLS-1:0]  fire_next;
    logic [VALUE_W-1:0]       x_position_reg;
    logic [VALUE_W-1:0]       y_position_reg;
    logic                     x_negative_reg;
    logic                     y_negative_reg;

    logic                     advance;
    logic                     in_take;

    logic [LOAD_W-1:0]        load_val;
    logic [QUOT_W-1:0]        load_quot;
    logic [LOAD_W-1:0]        load_rem;
    logic [RES_W-1:0]         load_res;
    logic [VALUE_W-1:0]       axis_dist;
    logic                     axis_armed;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && out_vld_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // value * ceil(2^(N+l)/P); quotient is exact for every N-bit value
    assign prod_next = PROD_W'(event_value[LOAD_W-1:0]) * PROD_W'(RECIP);

    assign load_val  = stage_val_reg[LOAD_W-1:0];
    assign load_quot = stage_prod_reg[PROD_W-1:DIV_SHIFT];
    assign load_rem  = load_val - LOAD_W'(load_quot * REPEAT_PERIOD);
    assign load_res  = RES_W'(load_rem);

    assign axis_dist  = (stage_val_reg >= midpoint_reg) ? (stage_val_reg - midpoint_reg)
                                                        : (midpoint_reg - stage_val_reg);
    assign axis_armed = axis_dist > deadzone_reg;

    always_comb
    begin
        hold_next = hold_reg;
        res_next  = res_reg;
        pos_next  = pos_reg;
        fire_next = '0;
        case (stage_func_reg)
            FUNC_TICK:
            begin
                for (int i = 0; i < NUM_CONTROLS; i++)
                begin
                    fire_next[i] = (hold_reg[i] == COUNTER_WIDTH'(1)) ||
                                   ((CMP_W'(hold_reg[i]) >= CMP_W'(repeat_delay_reg)) &&
                                    (res_reg[i] == '0));
                    if (hold_reg[i] != '0)
                    begin
                        if (hold_reg[i] == '1)
                        begin
                            hold_next[i] = COUNTER_WIDTH'(2);
                            res_next[i]  = RES_TWO;
                        end
                        else
                        begin
                            hold_next[i] = hold_reg[i] + 1'b1;
                            res_next[i]  = (res_reg[i] == RES_LAST) ? '0 : res_reg[i] + 1'b1;
                        end
                    end
                end
            end
            FUNC_BUTTON:
            begin
                hold_next[{1'b0, stage_idx_reg}] = COUNTER_WIDTH'(load_val);
                res_next[{1'b0, stage_idx_reg}]  = load_res;
            end
            FUNC_AXIS:
            begin
                hold_next[{1'b1, stage_idx_reg}] = axis_armed ? COUNTER_WIDTH'(1) : '0;
                res_next[{1'b1, stage_idx_reg}]  = axis_armed ? RES_ONE : '0;
                pos_next[stage_idx_reg]          = stage_val_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg     <= RESET_DEADZONE;
            midpoint_reg     <= RESET_MIDPOINT;
            repeat_delay_reg <= RESET_REPEAT_DELAY;
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            for (int i = 0; i < NUM_CONTROLS; i++)
            begin
                hold_reg[i] <= '0;
                res_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEADZONE:     deadzone_reg     <= cfg_data;
                    CFG_MIDPOINT:     midpoint_reg     <= cfg_data;
                    CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                hold_reg    <= hold_next;
                res_reg     <= res_next;
                pos_reg     <= pos_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_func_reg <= func_t'(func);
            stage_idx_reg  <= control_index;
            stage_val_reg  <= event_value;
            stage_prod_reg <= prod_next;
        end
        if (advance)
        begin
            fire_reg       <= fire_next;
            x_position_reg <= pos_next[0];
            y_position_reg <= pos_next[1];
            x_negative_reg <= pos_next[0] < midpoint_reg;
            y_negative_reg <= pos_next[1] < midpoint_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign fire_a     = fire_reg[0];
    assign fire_b     = fire_reg[1];
    assign fire_x     = fire_reg[2];
    assign fire_y     = fire_reg[3];
    assign x_position = x_position_reg;
    assign y_position = y_position_reg;
    assign x_negative = x_negative_reg;
    assign y_negative = y_negative_reg;

`ifndef NO_ASSERTIONS
    // only a tick can fire anything
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (stage_func_reg != FUNC_TICK)) |=>
            (out_vld_reg && (fire_reg == '0)))
        else $error("fire flag set by a non-tick transaction");

    // an axis event leaves its counter at zero or one
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (stage_func_reg == FUNC_AXIS)) |=>
            (hold_reg[{1'b1, $past(stage_idx_reg)}] <= COUNTER_WIDTH'(1)))
        else $error("axis counter not armed or cleared");

    // a released control carries a zero residue
    assert property (@(posedge clk) disable iff (!rst_n)
        ((hold_reg[0] != '0) || (res_reg[0] == '0)) &&
        ((hold_reg[1] != '0) || (res_reg[1] == '0)) &&
        ((hold_reg[2] != '0) || (res_reg[2] == '0)) &&
        ((hold_reg[3] != '0) || (res_reg[3] == '0)))
        else $error("residue out of step with zero counter");
`endif

endmodule
